/* rtl/bmhq_pkg.sv */
// Package with heap queue constants, commands and transaction structs.
`default_nettype none
package bmhq_pkg;
  localparam int unsigned Capacity = 1024;
  localparam int unsigned KeyBits = 32;
  localparam int unsigned TagBits = 16;
  localparam int unsigned SlotBits = $clog2(Capacity);
  localparam int unsigned CountBits = $clog2(Capacity + 1);

  localparam logic [2:0] CmdInsert = 3'd0;
  localparam logic [2:0] CmdExtract = 3'd1;
  localparam logic [2:0] CmdPeek = 3'd2;
  localparam logic [2:0] CmdReplace = 3'd3;
  localparam logic [2:0] CmdDelete = 3'd4;

  localparam logic KindUpdate = 1'b0;
  localparam logic KindFinal = 1'b1;

  typedef struct packed {
    logic [2:0] command;
    logic [KeyBits-1:0] key_in;
    logic [TagBits-1:0] tag_in;
    logic [SlotBits-1:0] slot_in;
  } req_t;

  typedef struct packed {
    logic kind;
    logic ok;
    logic [KeyBits-1:0] key_out;
    logic [TagBits-1:0] tag_out;
    logic [SlotBits-1:0] slot_out;
    logic [CountBits-1:0] count_out;
    logic last;
  } rsp_t;
endpackage
`default_nettype wire

/* rtl/bmhq_mem.sv */
// Heap entry storage: one write port, one registered read port.
`default_nettype none
module bmhq_mem (
  input  wire logic clk_i,
  input  wire logic we_i,
  input  wire logic [bmhq_pkg::SlotBits-1:0] waddr_i,
  input  wire logic [bmhq_pkg::KeyBits+bmhq_pkg::TagBits-1:0] wdata_i,
  input  wire logic [bmhq_pkg::SlotBits-1:0] raddr_i,
  output logic [bmhq_pkg::KeyBits+bmhq_pkg::TagBits-1:0] rdata_o
);
  import bmhq_pkg::*;
  logic [KeyBits+TagBits-1:0] mem_q [Capacity];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* rtl/binary_min_heap_queue.sv */
// Top level of the binary min-heap priority queue.
// Usage: drive a request on req_i with start high while busy is low; the
// transaction is taken at that edge and busy rises the next cycle. The
// block then emits zero or more position updates (kind 0, one per moved
// entry, with its new slot) and one final status (kind 1, last 1) on rsp_o,
// each valid for exactly one cycle while rsp_valid_o is high. The receiver
// cannot stall; every result is taken as shown.
// Peek and rejected commands move no entries. Insert climbs level by level
// towards the root and sift down descends level by level (one
// shared memory read port fetches parent or the two children in turn and a
// single key comparator decides).
// Only one transaction is in flight; busy stays high until the final
// status has been shown.
// Reset clears the entry count and sequencer; storage is not cleared, as
// no slot is used as an entry before it has been written.
`default_nettype none
module binary_min_heap_queue (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic busy,
  input  wire bmhq_pkg::req_t req_i,
  output logic rsp_valid_o,
  output bmhq_pkg::rsp_t rsp_o
);
  import bmhq_pkg::*;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StDecode = 4'd1;
  localparam logic [3:0] StLastRd = 4'd2;
  localparam logic [3:0] StLastWt = 4'd3;
  localparam logic [3:0] StUpRd = 4'd4;
  localparam logic [3:0] StUpCmp = 4'd5;
  localparam logic [3:0] StDnRdL = 4'd6;
  localparam logic [3:0] StDnRdR = 4'd7;
  localparam logic [3:0] StDnCmpL = 4'd8;
  localparam logic [3:0] StDnCmpR = 4'd9;
  localparam logic [3:0] StRootRd = 4'd10;
  localparam logic [3:0] StRootWt = 4'd11;
  localparam logic [3:0] StFinal = 4'd12;
  localparam logic [3:0] StChkRd = 4'd13;
  localparam logic [3:0] StChkWt = 4'd14;
  localparam logic [3:0] StMinRd = 4'd15;

  localparam int unsigned EntBits = KeyBits + TagBits;

  logic [3:0] state_q, state_d;
  logic [CountBits-1:0] count_q, count_d;
  req_t req_q, req_d;
  logic [KeyBits-1:0] key_q, key_d, bk_q, bk_d;
  logic [TagBits-1:0] tag_q, tag_d;
  logic [CountBits-1:0] pos_q, pos_d, bpos_q, bpos_d;
  logic [EntBits-1:0] rmin_q, rmin_d, bent_q, bent_d;
  logic ok_q, ok_d, fin_rem_q, fin_rem_d;

  logic we;
  logic [SlotBits-1:0] waddr, raddr;
  logic [EntBits-1:0] wdata, rdata;
  logic [KeyBits-1:0] rkey;
  logic key_lt;
  logic [KeyBits-1:0] cmp_a, cmp_b;
  logic [CountBits:0] lc, rc;

  bmhq_mem u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rkey = rdata[EntBits-1:TagBits];
  assign key_lt = cmp_a < cmp_b;
  assign lc = {pos_q, 1'b0};
  assign rc = {pos_q, 1'b1};
  assign busy = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    req_d = req_q;
    key_d = key_q;
    tag_d = tag_q;
    pos_d = pos_q;
    bpos_d = bpos_q;
    bk_d = bk_q;
    bent_d = bent_q;
    rmin_d = rmin_q;
    ok_d = ok_q;
    fin_rem_d = fin_rem_q;
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    cmp_a = key_q;
    cmp_b = rkey;
    rsp_valid_o = 1'b0;
    rsp_o = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          req_d = req_i;
          state_d = StDecode;
        end
        raddr = '0;
      end
      StDecode: begin
        raddr = '0;
        ok_d = 1'b0;
        fin_rem_d = 1'b0;
        state_d = StFinal;
        unique case (req_q.command)
          CmdInsert: begin
            if (count_q < CountBits'(Capacity)) begin
              ok_d = 1'b1;
              key_d = req_q.key_in;
              tag_d = req_q.tag_in;
              pos_d = count_q;
              count_d = count_q + 1'b1;
              state_d = StUpRd;
            end else begin
              state_d = StMinRd;
            end
          end
          CmdExtract, CmdReplace: begin
            if (count_q != '0) begin
              ok_d = 1'b1;
              fin_rem_d = 1'b1;
              state_d = StRootRd;
            end
          end
          CmdPeek: begin
            if (count_q != '0) begin
              ok_d = 1'b1;
              state_d = StMinRd;
            end
          end
          CmdDelete: begin
            if (CountBits'(req_q.slot_in) < count_q) begin
              ok_d = 1'b1;
              count_d = count_q - 1'b1;
              pos_d = CountBits'(req_q.slot_in);
              state_d = (CountBits'(req_q.slot_in) < count_q - 1'b1) ? StLastRd : StMinRd;
            end else begin
              state_d = StMinRd;
            end
          end
          default: state_d = StMinRd;
        endcase
      end
      StRootRd: begin
        raddr = '0;
        state_d = StRootWt;
      end
      StRootWt: begin
        rmin_d = rdata;
        pos_d = '0;
        if (req_q.command == CmdReplace) begin
          key_d = req_q.key_in;
          tag_d = req_q.tag_in;
          state_d = StDnRdL;
        end else begin
          count_d = count_q - 1'b1;
          state_d = (count_q == CountBits'(1)) ? StFinal : StLastRd;
        end
      end
      StLastRd: begin
        raddr = SlotBits'(count_q);
        state_d = StLastWt;
      end
      StLastWt: begin
        key_d = rkey;
        tag_d = rdata[TagBits-1:0];
        if (req_q.command == CmdDelete && pos_q != '0) begin
          raddr = SlotBits'(pos_q >> 1);
          state_d = StChkWt;
        end else begin
          state_d = StDnRdL;
        end
      end
      StChkRd: begin
        raddr = SlotBits'(pos_q >> 1);
        state_d = StChkWt;
      end
      StChkWt: begin
        cmp_a = key_q;
        cmp_b = rkey;
        state_d = key_lt ? StUpRd : StDnRdL;
      end
      StUpRd: begin
        raddr = SlotBits'(pos_q >> 1);
        state_d = (pos_q == '0) ? StMinRd : StUpCmp;
        if (pos_q == '0) begin
          we = 1'b1;
          waddr = '0;
          wdata = {key_q, tag_q};
          rsp_valid_o = 1'b1;
          rsp_o = '{KindUpdate, 1'b1, key_q, tag_q, '0, count_q, 1'b0};
        end
      end
      StUpCmp: begin
        cmp_a = key_q;
        cmp_b = rkey;
        we = 1'b1;
        waddr = SlotBits'(pos_q);
        rsp_valid_o = 1'b1;
        if (key_lt) begin
          wdata = rdata;
          rsp_o = '{KindUpdate, 1'b1, rkey, rdata[TagBits-1:0], SlotBits'(pos_q),
                    count_q, 1'b0};
          pos_d = pos_q >> 1;
          state_d = StUpRd;
        end else begin
          wdata = {key_q, tag_q};
          rsp_o = '{KindUpdate, 1'b1, key_q, tag_q, SlotBits'(pos_q), count_q, 1'b0};
          state_d = StMinRd;
        end
      end
      StDnRdL: begin
        bpos_d = pos_q;
        bk_d = key_q;
        bent_d = {key_q, tag_q};
        state_d = StDnRdR;
      end
      StDnRdR: begin
        raddr = SlotBits'(lc);
        state_d = StDnCmpL;
      end
      StDnCmpL: begin
        raddr = SlotBits'(rc);
        cmp_a = rkey;
        cmp_b = bk_q;
        if (pos_q != '0 && lc < (CountBits+1)'(count_q) && key_lt) begin
          bpos_d = CountBits'(lc);
          bk_d = rkey;
          bent_d = rdata;
        end
        state_d = StDnCmpR;
      end
      StDnCmpR: begin
        cmp_a = rkey;
        cmp_b = bk_q;
        we = 1'b1;
        waddr = SlotBits'(pos_q);
        rsp_valid_o = 1'b1;
        if (rc < (CountBits+1)'(count_q) && key_lt) begin
          wdata = rdata;
          rsp_o = '{KindUpdate, 1'b1, rkey, rdata[TagBits-1:0], SlotBits'(pos_q),
                    count_q, 1'b0};
          pos_d = CountBits'(rc);
          state_d = StDnRdL;
        end else if (bpos_q != pos_q) begin
          wdata = bent_q;
          rsp_o = '{KindUpdate, 1'b1, bk_q, bent_q[TagBits-1:0], SlotBits'(pos_q),
                    count_q, 1'b0};
          pos_d = bpos_q;
          state_d = StDnRdL;
        end else begin
          wdata = {key_q, tag_q};
          rsp_o = '{KindUpdate, 1'b1, key_q, tag_q, SlotBits'(pos_q), count_q, 1'b0};
          state_d = fin_rem_q ? StFinal : StMinRd;
        end
      end
      StMinRd: begin
        raddr = '0;
        fin_rem_d = 1'b0;
        state_d = StFinal;
      end
      StFinal: begin
        rsp_valid_o = 1'b1;
        if (fin_rem_q) begin
          rsp_o = '{KindFinal, ok_q, rmin_q[EntBits-1:TagBits], rmin_q[TagBits-1:0],
                    '0, count_q, 1'b1};
        end else if (count_q != '0 && req_q.command != CmdExtract &&
                     !(req_q.command == CmdReplace || req_q.command == CmdPeek) || 
                     (req_q.command == CmdPeek && ok_q)) begin
          rsp_o = '{KindFinal, ok_q, rkey, rdata[TagBits-1:0], '0, count_q, 1'b1};
        end else begin
          rsp_o = '{KindFinal, ok_q, '0, '0, '0, count_q, 1'b1};
        end
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      ok_q <= 1'b0;
      fin_rem_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ok_q <= ok_d;
      fin_rem_q <= fin_rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    key_q <= key_d;
    tag_q <= tag_d;
    pos_q <= pos_d;
    bpos_q <= bpos_d;
    bk_q <= bk_d;
    bent_q <= bent_d;
    rmin_q <= rmin_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountBits'(Capacity))
    else $error("entry count above capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.last |=> !busy)
    else $error("busy after final status");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> busy)
    else $error("result while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.kind == rsp_o.last))
    else $error("kind and last disagree");
endmodule
`default_nettype wire
